/* hdl/dcm_pkg.sv */
// ----------------------------------------------------------------------------
// dcm_pkg
// Shared constants, register indexes and saturation helper for the DC motor
// electrical model.
// ----------------------------------------------------------------------------
`default_nettype none

package dcm_pkg;

	localparam int VALUE_WIDTH = 32;
	// results saturate to at most 32 bits
	localparam int SAT_W       = (VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH;
	localparam int DATA_W      = 32;
	localparam int PAR_W       = 31;
	localparam int EFF_W       = 17;
	localparam int OPND_W      = 33;
	localparam int PROD_W      = 2 * OPND_W;
	localparam int FRAC_W      = 16;
	localparam int DVD_W       = DATA_W + FRAC_W;
	localparam int CFG_IDX_W   = 4;

	// 9.5493 in Q16.16
	localparam logic signed [OPND_W-1:0] EMF_SCALE_Q16 = 33'sd625823;
	localparam logic [PAR_W-1:0]         ONE_Q16       = 31'd65536;

	localparam logic [CFG_IDX_W-1:0] CFG_RESISTANCE = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INDUCTANCE = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BACK_EMF   = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TORQUE_K   = 4'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FRICTION   = 4'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_GEAR_RATIO = 4'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_GEAR_EFF   = 4'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_VOLT_LIMIT = 4'd7;

	localparam logic OP_SET_VOLTAGE = 1'b0;
	localparam logic OP_TICK        = 1'b1;

	function automatic logic signed [DATA_W-1:0] sat_val(input logic signed [PROD_W-1:0] x);
		logic signed [PROD_W-1:0] hi;
		logic signed [PROD_W-1:0] lo;
		logic signed [PROD_W-1:0] r;
		hi = (PROD_W'(1) <<< (SAT_W - 1)) - PROD_W'(1);
		lo = -hi - PROD_W'(1);
		if (x > hi) begin
			r = hi;
		end else if (x < lo) begin
			r = lo;
		end else begin
			r = x;
		end
		return r[DATA_W-1:0];
	endfunction

endpackage

`default_nettype wire

/* hdl/dc_motor_electrical_model.sv */
// ----------------------------------------------------------------------------
// dc_motor_electrical_model
// DC motor emulator: stores a clamped voltage command and advances the
// winding current by one forward Euler step per tick, reporting drive torque.
// ----------------------------------------------------------------------------
// A set-voltage request goes from idle straight to the output load; a tick request
// runs nine products through one shared 33x33 multiplier (each a multiply state
// and a write-back state) and two Q16.16 quotients through one restoring divider
// that resolves one quotient bit per cycle (48 bits each), plus the current
// clamp and the output load. The block takes no request while a tick is being
// worked, and a finished result waits in the output register until taken. The user
// must write registers through the cfg port while the block is idle; it is not enforced.
`default_nettype none

module dc_motor_electrical_model (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// cfg
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [dcm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [dcm_pkg::DATA_W-1:0]     cfg_data,
	// request
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [95:0] s_tdata,  // voltage_command, joint_velocity, time_step
	input  wire logic        s_tuser,  // operation
	// result
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [95:0]      m_tdata   // torque, current, applied_voltage
);

	localparam int DW = dcm_pkg::DATA_W;
	localparam int PW = dcm_pkg::PAR_W;
	localparam int OW = dcm_pkg::OPND_W;
	localparam int XW = dcm_pkg::PROD_W;
	localparam int FW = dcm_pkg::FRAC_W;
	localparam int QW = dcm_pkg::DVD_W;
	localparam int CW = $clog2(QW);

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL, ST_MULWB, ST_DIVLD, ST_DIV, ST_DIVWB, ST_CLAMP, ST_OUT
	} state_t;

	typedef enum logic [3:0] {
		STP_SPEED, STP_KT, STP_FRIC, STP_RATIO, STP_EFF, STP_KE, STP_EMF,
		STP_RES, STP_DIVL, STP_DT, STP_DIVR
	} step_t;

	state_t state_q;
	step_t  step_q;

	// configuration
	logic [PW-1:0]                res_q, ind_q, ke_q, kt_q, fric_q, ratio_q;
	logic [dcm_pkg::EFF_W-1:0]    eff_q;
	logic signed [DW-1:0]         vlim_q;

	// model state and working registers
	logic signed [DW-1:0] cur_q, volt_q, torq_q;
	logic signed [DW-1:0] jv_q, spd_q, t_q, e_q, num_q, vol_q, inew_q, vr_q;
	logic [DW-1:0]        dt_q;
	logic signed [XW-1:0] prod_q;

	// divider
	logic [QW-1:0] dvd_q;
	logic [DW-1:0] rem_q;
	logic [PW-1:0] den_q;
	logic          div_neg_q;
	logic [CW-1:0] div_cnt_q;

	logic [95:0]   out_q;
	logic          out_valid_q;

	logic signed [OW-1:0] mul_a, mul_b;
	logic signed [DW-1:0] qm;
	logic [DW-1:0]        div_shift;
	logic [DW:0]          div_diff;
	logic signed [DW-1:0] div_num;
	logic [PW-1:0]        div_den;
	logic [DW-1:0]        div_mag;
	logic signed [XW-1:0] div_res;
	logic signed [DW-1:0] cmd;
	logic signed [DW-1:0] cmd_clamped;
	logic [DW-1:0]        abs_inew, abs_vr;
	logic                 same_sign;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_q;

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (step_q)
			STP_SPEED: begin
				mul_a = OW'(jv_q);
				mul_b = $signed({2'b00, ratio_q});
			end
			STP_KT: begin
				mul_a = OW'(cur_q);
				mul_b = $signed({2'b00, kt_q});
			end
			STP_FRIC: begin
				mul_a = OW'(spd_q);
				mul_b = $signed({2'b00, fric_q});
			end
			STP_RATIO: begin
				mul_a = OW'(t_q);
				mul_b = $signed({2'b00, ratio_q});
			end
			STP_EFF: begin
				mul_a = OW'(t_q);
				mul_b = $signed({{(OW - dcm_pkg::EFF_W){1'b0}}, eff_q});
			end
			STP_KE: begin
				mul_a = OW'(spd_q);
				mul_b = $signed({2'b00, ke_q});
			end
			STP_EMF: begin
				mul_a = OW'(e_q);
				mul_b = dcm_pkg::EMF_SCALE_Q16;
			end
			STP_RES: begin
				mul_a = OW'(cur_q);
				mul_b = $signed({2'b00, res_q});
			end
			STP_DT: begin
				mul_a = OW'(vol_q);
				mul_b = $signed({1'b0, dt_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// floor to Q16.16 by arithmetic shift, then saturate
	assign qm = dcm_pkg::sat_val(prod_q >>> FW);

	// divider operand select and one restoring step
	always_comb begin
		if (step_q == STP_DIVR) begin
			div_num = volt_q;
			div_den = res_q;
		end else begin
			div_num = num_q;
			div_den = ind_q;
		end
	end
	assign div_mag   = div_num[DW-1] ? (~div_num + 1'b1) : div_num;
	assign div_shift = {rem_q[DW-2:0], dvd_q[QW-1]};
	assign div_diff  = {1'b0, div_shift} - {2'b00, den_q};
	assign div_res   = div_neg_q ? -$signed({{(XW - QW){1'b0}}, dvd_q})
	                             :  $signed({{(XW - QW){1'b0}}, dvd_q});

	// voltage command clamp
	assign cmd = $signed(s_tdata[DW-1:0]);
	always_comb begin
		cmd_clamped = cmd;
		if (vlim_q > 0) begin
			if (cmd < -vlim_q) begin
				cmd_clamped = -vlim_q;
			end else if (cmd > vlim_q) begin
				cmd_clamped = vlim_q;
			end
		end
	end

	assign abs_inew  = inew_q[DW-1] ? (~inew_q + 1'b1) : inew_q;
	assign abs_vr    = vr_q[DW-1] ? (~vr_q + 1'b1) : vr_q;
	assign same_sign = ((inew_q > 0) && (volt_q > 0)) || ((inew_q < 0) && (volt_q < 0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= STP_SPEED;
			res_q       <= dcm_pkg::ONE_Q16;
			ind_q       <= dcm_pkg::ONE_Q16;
			ke_q        <= '0;
			kt_q        <= '0;
			fric_q      <= '0;
			ratio_q     <= dcm_pkg::ONE_Q16;
			eff_q       <= dcm_pkg::EFF_W'(dcm_pkg::ONE_Q16);
			vlim_q      <= -DW'(dcm_pkg::ONE_Q16);
			cur_q       <= '0;
			volt_q      <= '0;
			torq_q      <= '0;
			out_valid_q <= 1'b0;
			div_cnt_q   <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					dcm_pkg::CFG_RESISTANCE: res_q   <= cfg_data[PW-1:0];
					dcm_pkg::CFG_INDUCTANCE: ind_q   <= cfg_data[PW-1:0];
					dcm_pkg::CFG_BACK_EMF:   ke_q    <= cfg_data[PW-1:0];
					dcm_pkg::CFG_TORQUE_K:   kt_q    <= cfg_data[PW-1:0];
					dcm_pkg::CFG_FRICTION:   fric_q  <= cfg_data[PW-1:0];
					dcm_pkg::CFG_GEAR_RATIO: ratio_q <= cfg_data[PW-1:0];
					dcm_pkg::CFG_GEAR_EFF:   eff_q   <= cfg_data[dcm_pkg::EFF_W-1:0];
					dcm_pkg::CFG_VOLT_LIMIT: vlim_q  <= $signed(cfg_data);
					default: ;
				endcase
			end

			// the output load below takes over when a result is waiting to go out
			if (out_valid_q && m_tready && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						if (s_tuser == dcm_pkg::OP_SET_VOLTAGE) begin
							volt_q  <= dcm_pkg::sat_val(XW'(cmd_clamped));
							state_q <= ST_OUT;
						end else begin
							jv_q    <= $signed(s_tdata[2*DW-1:DW]);
							dt_q    <= s_tdata[3*DW-1:2*DW];
							step_q  <= STP_SPEED;
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					prod_q  <= mul_a * mul_b;
					state_q <= ST_MULWB;
				end
				ST_MULWB: begin
					case (step_q)
						STP_SPEED: begin
							spd_q   <= qm;
							step_q  <= STP_KT;
							state_q <= ST_MUL;
						end
						STP_KT: begin
							t_q     <= qm;
							step_q  <= STP_FRIC;
							state_q <= ST_MUL;
						end
						STP_FRIC: begin
							t_q     <= dcm_pkg::sat_val(XW'(t_q) - XW'(qm));
							step_q  <= STP_RATIO;
							state_q <= ST_MUL;
						end
						STP_RATIO: begin
							t_q     <= qm;
							step_q  <= STP_EFF;
							state_q <= ST_MUL;
						end
						STP_EFF: begin
							torq_q  <= qm;
							step_q  <= STP_KE;
							state_q <= ST_MUL;
						end
						STP_KE: begin
							e_q     <= qm;
							step_q  <= STP_EMF;
							state_q <= ST_MUL;
						end
						STP_EMF: begin
							e_q     <= qm;
							step_q  <= STP_RES;
							state_q <= ST_MUL;
						end
						STP_RES: begin
							num_q   <= dcm_pkg::sat_val(XW'(volt_q) - XW'(e_q) - XW'(qm));
							step_q  <= STP_DIVL;
							state_q <= ST_DIVLD;
						end
						STP_DT: begin
							// floor of vol*dt in Q0.32 scaling
							inew_q  <= dcm_pkg::sat_val((prod_q >>> DW) + XW'(cur_q));
							step_q  <= STP_DIVR;
							state_q <= ST_DIVLD;
						end
						default: begin
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_DIVLD: begin
					dvd_q     <= {div_mag, {FW{1'b0}}};
					rem_q     <= '0;
					den_q     <= (div_den == '0) ? PW'(1) : div_den;
					div_neg_q <= div_num[DW-1];
					div_cnt_q <= '0;
					state_q   <= ST_DIV;
				end
				ST_DIV: begin
					if (!div_diff[DW]) begin
						rem_q <= div_diff[DW-1:0];
						dvd_q <= {dvd_q[QW-2:0], 1'b1};
					end else begin
						rem_q <= div_shift;
						dvd_q <= {dvd_q[QW-2:0], 1'b0};
					end
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == CW'(QW - 1)) begin
						state_q <= ST_DIVWB;
					end
				end
				ST_DIVWB: begin
					if (step_q == STP_DIVR) begin
						vr_q    <= dcm_pkg::sat_val(div_res);
						state_q <= ST_CLAMP;
					end else begin
						vol_q   <= dcm_pkg::sat_val(div_res);
						step_q  <= STP_DT;
						state_q <= ST_MUL;
					end
				end
				ST_CLAMP: begin
					// limit the current to V/R when it overshoots in the drive direction
					cur_q   <= (same_sign && (abs_inew > abs_vr)) ? vr_q : inew_q;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || m_tready) begin
						out_q       <= {volt_q, cur_q, torq_q};
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* hdl/dcm_checker.sv */
// ----------------------------------------------------------------------------
// dcm_checker
// Port-level checks on the DC motor electrical model, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dcm_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [95:0] m_tdata
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result changed while stalled");

	// the block is busy right after taking a request
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request taken while previous one in flight");

	// a result only appears out of a busy phase
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result without request");

	// set voltage answers through the output state with no wait when the output is free
	a_set_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser == dcm_pkg::OP_SET_VOLTAGE) && !m_tvalid)
		|=> ##1 m_tvalid)
		else $error("set voltage result late");

endmodule

bind dc_motor_electrical_model dcm_checker u_dcm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
